// ===== rtl/core/bmpd_pkg.sv =====
// Shared types and constants for the bitmap pixel array decoder.
package bmpd_pkg;

    localparam int MAX_WIDTH  = 4096;
    localparam int MAX_HEIGHT = 4096;
    localparam int DIM_W      = 13;   // register width of width/height
    localparam int POS_W      = 12;   // column/row output width
    localparam int BYTE_POS_W = 15;   // bytes per padded row, up to 4*MAX_WIDTH
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

    typedef enum logic [1:0] {
        DEPTH_4BPP  = 2'd0,
        DEPTH_8BPP  = 2'd1,
        DEPTH_24BPP = 2'd2,
        DEPTH_32BPP = 2'd3
    } depth_t;

    typedef enum logic [1:0] {
        REG_PIXEL_DEPTH  = 2'd0,
        REG_IMAGE_WIDTH  = 2'd1,
        REG_IMAGE_HEIGHT = 2'd2
    } reg_index_t;

    // Frame geometry derived from the registers
    typedef struct packed {
        depth_t                  depth;
        logic [DIM_W-1:0]        width;
        logic [DIM_W-1:0]        height;
        logic [BYTE_POS_W-1:0]   data_bytes;
        logic [BYTE_POS_W-1:0]   padded_bytes;
        logic                    restart;
    } geom_t;

    typedef struct packed {
        logic [7:0]       red;
        logic [7:0]       green;
        logic [7:0]       blue;
        logic [POS_W-1:0] column;
        logic [POS_W-1:0] row;
        logic             end_of_row;
        logic             end_of_frame;
        logic             last_of_run;
    } pixel_t;

    // Pixels produced by one byte: zero, one or two
    typedef struct packed {
        logic [1:0] count;
        pixel_t     pix1;
        pixel_t     pix0;
    } push_t;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                   input logic [DIM_W-1:0] maxv);
        logic [DIM_W-1:0] r;
        if (v == '0)
            r = DIM_W'(1);
        else if (v > maxv)
            r = maxv;
        else
            r = v;
        return r;
    endfunction

endpackage

// ===== rtl/core/bmpd_cfg.sv =====
// Configuration registers and row geometry of the bitmap decoder.
module bmpd_cfg (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [1:0]                cfg_addr,
    input  logic [bmpd_pkg::DIM_W-1:0] cfg_wdata,
    output bmpd_pkg::geom_t           geom
);
    import bmpd_pkg::*;

    depth_t           depth_reg;
    logic [DIM_W-1:0] width_reg;
    logic [DIM_W-1:0] height_reg;

    logic             wr;
    logic             restart;
    logic [DIM_W-1:0] w;
    logic [BYTE_POS_W-1:0] w_ext;
    logic [BYTE_POS_W-1:0] data_bytes;
    logic [BYTE_POS_W-1:0] padded;

    assign cfg_ready = 1'b1;
    assign wr        = cfg_valid && cfg_ready;
    // a write to a listed register clears the frame position on the same edge
    assign restart   = wr && (cfg_addr == REG_PIXEL_DEPTH || cfg_addr == REG_IMAGE_WIDTH
                              || cfg_addr == REG_IMAGE_HEIGHT);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            depth_reg   <= DEPTH_24BPP;
            width_reg   <= DIM_W'(1);
            height_reg  <= DIM_W'(1);
        end else begin
            if (wr) begin
                unique case (reg_index_t'(cfg_addr))
                    REG_PIXEL_DEPTH: begin
                        depth_reg   <= depth_t'(cfg_wdata[1:0]);
                    end
                    REG_IMAGE_WIDTH: begin
                        width_reg   <= cfg_wdata;
                    end
                    REG_IMAGE_HEIGHT: begin
                        height_reg  <= cfg_wdata;
                    end
                    default: ;
                endcase
            end
        end
    end

    assign w     = clamp_dim(width_reg, DIM_W'(MAX_WIDTH));
    assign w_ext = BYTE_POS_W'(w);

    always_comb begin
        unique case (depth_reg)
            DEPTH_4BPP:  data_bytes = (w_ext + BYTE_POS_W'(1)) >> 1;
            DEPTH_8BPP:  data_bytes = w_ext;
            DEPTH_24BPP: data_bytes = w_ext + (w_ext << 1);
            DEPTH_32BPP: data_bytes = w_ext << 2;
            default:     data_bytes = w_ext;
        endcase
    end

    // round up to a whole 32-bit word
    assign padded = (data_bytes + BYTE_POS_W'(3)) & ~BYTE_POS_W'(3);

    assign geom.depth        = depth_reg;
    assign geom.width        = w;
    assign geom.height       = clamp_dim(height_reg, DIM_W'(MAX_HEIGHT));
    assign geom.data_bytes   = data_bytes;
    assign geom.padded_bytes = padded;
    assign geom.restart      = restart;

endmodule

// ===== rtl/core/bmpd_decode.sv =====
// Byte position tracking and pixel assembly for each accepted byte.
module bmpd_decode (
    input  logic              aclk,
    input  logic              aresetn,
    input  bmpd_pkg::geom_t   geom,
    input  logic              accept,
    input  logic [7:0]        data_byte,
    output bmpd_pkg::push_t   push
);
    import bmpd_pkg::*;

    logic [BYTE_POS_W-1:0] byte_in_row_reg, byte_in_row_next;
    logic [15:0]           held_reg, held_next;
    logic [1:0]            sub_reg, sub_next;       // byte within a 24-bit pixel
    logic [DIM_W-1:0]      column_reg, column_next;
    logic [DIM_W-1:0]      row_reg, row_next;
    logic                  frame_done_reg, frame_done_next;

    logic [DIM_W-1:0]      col_p1, col_p2, row_p1;
    logic                  last_row;
    logic [BYTE_POS_W-1:0] bir_p1;
    logic [1:0]            sub;
    logic [3:0]            hi, lo;

    assign col_p1   = column_reg + DIM_W'(1);
    assign col_p2   = column_reg + DIM_W'(2);
    assign row_p1   = row_reg + DIM_W'(1);
    assign last_row = row_p1 >= geom.height;
    assign bir_p1   = byte_in_row_reg + BYTE_POS_W'(1);
    assign sub      = (geom.depth == DEPTH_32BPP) ? byte_in_row_reg[1:0] : sub_reg;
    assign hi       = data_byte[7:4];
    assign lo       = data_byte[3:0];

    always_comb begin
        byte_in_row_next = byte_in_row_reg;
        held_next        = held_reg;
        sub_next         = sub_reg;
        column_next      = column_reg;
        row_next         = row_reg;
        frame_done_next  = frame_done_reg;

        push.count = 2'd0;
        push.pix0  = '0;
        push.pix1  = '0;
        push.pix0.column       = column_reg[POS_W-1:0];
        push.pix0.row          = row_reg[POS_W-1:0];
        push.pix0.end_of_row   = col_p1 >= geom.width;
        push.pix0.end_of_frame = (col_p1 >= geom.width) && last_row;
        push.pix1.column       = col_p1[POS_W-1:0];
        push.pix1.row          = row_reg[POS_W-1:0];
        push.pix1.end_of_row   = col_p2 >= geom.width;
        push.pix1.end_of_frame = (col_p2 >= geom.width) && last_row;
        push.pix1.last_of_run  = 1'b1;

        if (accept && !frame_done_reg) begin
            if (byte_in_row_reg < geom.data_bytes) begin
                unique case (geom.depth)
                    DEPTH_4BPP: begin
                        push.pix0.red   = {4'd0, hi};
                        push.pix0.green = {4'd0, hi};
                        push.pix0.blue  = {4'd0, hi};
                        push.pix1.red   = {4'd0, lo};
                        push.pix1.green = {4'd0, lo};
                        push.pix1.blue  = {4'd0, lo};
                        // spare low nibble of an odd-width row is dropped
                        if (col_p1 < geom.width) begin
                            push.count  = 2'd2;
                            column_next = col_p2;
                        end else begin
                            push.count  = 2'd1;
                            column_next = col_p1;
                        end
                    end
                    DEPTH_8BPP: begin
                        push.pix0.red   = data_byte;
                        push.pix0.green = data_byte;
                        push.pix0.blue  = data_byte;
                        push.count      = 2'd1;
                        column_next     = col_p1;
                    end
                    DEPTH_24BPP, DEPTH_32BPP: begin
                        unique case (sub)
                            2'd0: held_next[7:0]  = data_byte;
                            2'd1: held_next[15:8] = data_byte;
                            2'd2: begin
                                push.pix0.red   = data_byte;
                                push.pix0.green = held_reg[15:8];
                                push.pix0.blue  = held_reg[7:0];
                                push.count      = 2'd1;
                                column_next     = col_p1;
                            end
                            default: ;  // reserved byte at 32 bpp
                        endcase
                        sub_next = (sub_reg == 2'd2) ? 2'd0 : sub_reg + 2'd1;
                    end
                    default: ;
                endcase
            end
            push.pix0.last_of_run = (push.count == 2'd1);

            byte_in_row_next = bir_p1;
            if (bir_p1 >= geom.padded_bytes) begin
                byte_in_row_next = '0;
                column_next      = '0;
                sub_next         = 2'd0;
                row_next         = row_p1;
                if (last_row)
                    frame_done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || geom.restart) begin
            byte_in_row_reg <= '0;
            held_reg        <= '0;
            sub_reg         <= 2'd0;
            column_reg      <= '0;
            row_reg         <= '0;
            frame_done_reg  <= 1'b0;
        end else begin
            byte_in_row_reg <= byte_in_row_next;
            held_reg        <= held_next;
            sub_reg         <= sub_next;
            column_reg      <= column_next;
            row_reg         <= row_next;
            frame_done_reg  <= frame_done_next;
        end
    end

    a_col_in_row: assert property (@(posedge aclk) disable iff (!aresetn)
        (push.count != 2'd0) |-> (column_reg < geom.width))
        else $error("pixel column beyond image width");

    a_no_pixels_after_frame: assert property (@(posedge aclk) disable iff (!aresetn)
        frame_done_reg |-> (push.count == 2'd0))
        else $error("pixel produced after end of frame");

    a_frame_end_sets_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (push.count == 2'd1 && push.pix0.end_of_frame && !geom.restart)
            |=> frame_done_reg || (byte_in_row_reg != '0))
        else $error("end of frame pixel inconsistent with frame state");

endmodule

// ===== rtl/core/bmpd_fifo.sv =====
// Pixel queue: takes up to two pixels per cycle, hands out one per cycle while out_ready is high.
module bmpd_fifo (
    input  logic              aclk,
    input  logic              aresetn,
    input  bmpd_pkg::push_t   push,
    output logic              room,      // space for two pixels
    output logic              out_valid,
    input  logic              out_ready,
    output bmpd_pkg::pixel_t  out_pixel
);
    import bmpd_pkg::*;

    pixel_t               mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [FIFO_AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [FIFO_CW-1:0]   count_reg, count_next;
    logic                 pop;
    logic [FIFO_AW-1:0]   wr_ptr_p1;

    assign pop       = out_valid && out_ready;
    assign out_valid = count_reg != '0;
    assign room      = count_reg <= FIFO_CW'(FIFO_DEPTH - 2);
    assign out_pixel = mem[rd_ptr_reg];
    assign wr_ptr_p1 = wr_ptr_reg + FIFO_AW'(1);

    always_comb begin
        wr_ptr_next = wr_ptr_reg + FIFO_AW'(push.count);
        rd_ptr_next = pop ? rd_ptr_reg + FIFO_AW'(1) : rd_ptr_reg;
        count_next  = count_reg + FIFO_CW'(push.count) - FIFO_CW'(pop);
    end

    always_ff @(posedge aclk) begin
        if (push.count != 2'd0)
            mem[wr_ptr_reg] <= push.pix0;
        if (push.count == 2'd2)
            mem[wr_ptr_p1] <= push.pix1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= FIFO_CW'(FIFO_DEPTH))
        else $error("pixel queue overflow");

    a_push_has_room: assert property (@(posedge aclk) disable iff (!aresetn)
        (push.count != 2'd0) |-> room)
        else $error("pixels pushed without room");

    a_pop_drains: assert property (@(posedge aclk) disable iff (!aresetn)
        (pop && push.count == 2'd0) |=> (count_reg == $past(count_reg) - FIFO_CW'(1)))
        else $error("pixel queue count lost on pop");

endmodule

// ===== rtl/core/bmp_pixel_array_decoder.sv =====
// Top level of the bitmap pixel array decoder.
// Takes the pixel array of a bitmap one byte per request on s_* and returns
// pixels with their column and row on m_*. Bytes are taken one per clock while
// s_tready is high; each byte is decoded in the cycle it is accepted and its
// pixels land in a four-entry pixel queue that feeds the output one pixel per
// clock while m_tready is high. At 8, 24 and 32 bpp the block therefore
// sustains one byte per cycle; at 4 bpp each byte yields two pixels and the
// single-pixel output port sets the rate, holding s_tready low. A register
// write restarts the frame; bytes after the last row are accepted and
// dropped until the next write or reset.
module bmp_pixel_array_decoder (
    input  logic                      aclk,
    input  logic                      aresetn,
    // configuration writes
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [1:0]                cfg_addr,
    input  logic [bmpd_pkg::DIM_W-1:0] cfg_wdata,
    // byte input
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [7:0]                s_tdata,   // [7:0] data_byte
    // pixel output
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [47:0]               m_tdata,   // red, green, blue, column, row
    output logic [1:0]                m_tuser,   // end_of_row, last_of_run
    output logic                      m_tlast    // end_of_frame
);
    import bmpd_pkg::*;

    geom_t  geom;
    push_t  push;
    pixel_t pix;
    logic   room;

    bmpd_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .geom      (geom)
    );

    assign s_tready = room;

    bmpd_decode u_decode (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .geom      (geom),
        .accept    (s_tvalid && s_tready),
        .data_byte (s_tdata),
        .push      (push)
    );

    bmpd_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .room      (room),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_pixel (pix)
    );

    assign m_tdata = {pix.row, pix.column, pix.blue, pix.green, pix.red};
    assign m_tuser = {pix.last_of_run, pix.end_of_row};
    assign m_tlast = pix.end_of_frame;

endmodule
